>>> sv/fmrb_pkg.sv
`timescale 1ns / 1ps
package fmrb_pkg;

  localparam int RING_BYTES_DEF = 4096;
  localparam int KEY_BYTES_DEF  = 8;
  localparam int TAG_BYTES      = 4;
  localparam int LEN_WORD_BYTES = 4;
  localparam int EXT_WORD_BYTES = 4;
  localparam int MIN_RING       = 32;

  localparam int LEN_W     = 13;
  localparam int CFG_W     = 32;
  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 184;

  typedef enum logic [0:0] {
    REG_RING_LENGTH = 1'b0,
    REG_MAGIC_TAG   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_BEGIN_WR = 3'd0,
    OP_WR_BYTE  = 3'd1,
    OP_BEGIN_RD = 3'd2,
    OP_RD_BYTE  = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_ILLEGAL  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_TAG   = 3'd3,
    ST_SMALL = 3'd4,
    ST_SEQ   = 3'd5
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_HDR,
    S_WR_TAIL,
    S_RD_HDR,
    S_RD_CHK,
    S_RD_BYTE,
    S_RD_TAIL,
    S_TAIL_CHK,
    S_EMIT
  } eng_state_t;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  length;
    logic [31:0]       ext;
    logic [63:0]       unique_key;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  max_length;
  } item_t;

  typedef struct packed {
    st_t               status;
    logic [LEN_W-1:0]  msg_length;
    logic [31:0]       msg_ext;
    logic [63:0]       msg_key;
    logic [7:0]        read_byte;
    logic              last;
    logic [31:0]       enqueued_count;
    logic [31:0]       dequeued_count;
  } result_t;

endpackage

>>> sv/fmrb_ram.sv
`timescale 1ns / 1ps
module fmrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/fmrb_front.sv
`timescale 1ns / 1ps
module fmrb_front
  import fmrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [2:0]           s_tuser,
  output item_t                item,
  output logic                 item_valid,
  input  logic                 item_pop
);

  item_t      q [2];
  logic       wr_idx, rd_idx;
  logic [1:0] count;
  item_t      in_item;
  logic       push;

  // classify the operation code; unused codes fold into one illegal class
  always_comb begin
    case (op_t'(s_tuser))
      OP_BEGIN_WR: in_item.op = OP_BEGIN_WR;
      OP_WR_BYTE:  in_item.op = OP_WR_BYTE;
      OP_BEGIN_RD: in_item.op = OP_BEGIN_RD;
      OP_RD_BYTE:  in_item.op = OP_RD_BYTE;
      OP_CLEAR:    in_item.op = OP_CLEAR;
      default:     in_item.op = OP_ILLEGAL;
    endcase
    in_item.length     = s_tdata[12:0];
    in_item.ext        = s_tdata[44:13];
    in_item.unique_key = s_tdata[108:45];
    in_item.data_byte  = s_tdata[116:109];
    in_item.max_length = s_tdata[129:117];
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_idx] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_idx <= ~wr_idx;
      if (item_pop) rd_idx <= ~rd_idx;
      count <= count + {1'b0, push} - {1'b0, item_pop};
    end
  end

endmodule

>>> sv/fmrb_engine.sv
`timescale 1ns / 1ps
module fmrb_engine
  import fmrb_pkg::*;
#(
  parameter int RING_BYTES = RING_BYTES_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  item_t            item,
  input  logic             item_valid,
  output logic             item_pop,
  output result_t          res,
  output logic             res_valid,
  input  logic             res_ready
);

  localparam int PW          = $clog2(RING_BYTES);
  localparam int LW          = $clog2(RING_BYTES + 1);
  localparam int CW          = (LW > 14) ? LW : 14;
  localparam int HB          = TAG_BYTES + LEN_WORD_BYTES + EXT_WORD_BYTES + KEY_BYTES;
  localparam int FRAME_EXTRA = HB + TAG_BYTES;
  localparam int CNT_W       = $clog2(HB + 1);
  localparam int HI_W        = $clog2(HB);

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [LW-1:0] len);
    logic [LW-1:0] nxt;
    nxt = LW'(p) + LW'(1);
    return (nxt == len) ? '0 : PW'(nxt);
  endfunction

  eng_state_t       state, state_next;
  logic [LW-1:0]    ring_len, ring_len_next;
  logic [31:0]      magic, magic_next;
  logic [PW-1:0]    wptr, wptr_next, rptr, rptr_next;
  logic [PW-1:0]    swptr, swptr_next, srptr, srptr_next;
  logic [PW-1:0]    wk, wk_next;
  logic [LEN_W-1:0] wleft, wleft_next, rleft, rleft_next;
  logic             wopen, wopen_next, ropen, ropen_next;
  logic [31:0]      enq, enq_next, deq, deq_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  item_t            cur, cur_next;
  result_t          res_next;
  logic             res_valid_next;

  logic [7:0]       hbuf [HB];
  logic             hb_we;
  logic [HI_W-1:0]  hb_idx;

  logic             ram_we;
  logic [PW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic [CW-1:0]    free_b, framed_c;
  logic [HB*8-1:0]  hdr_vec;
  logic [31:0]      h_tag, h_framed, h_ext;
  logic [63:0]      h_key;
  logic [LEN_W-1:0] dlen;
  logic [CNT_W-1:0] rd_n;
  logic [LEN_W-1:0] cfg_len;

  fmrb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    h_key = '0;
    for (int i = 0; i < 4; i++) begin
      h_tag[i*8 +: 8]    = hbuf[i];
      h_framed[i*8 +: 8] = hbuf[TAG_BYTES + i];
      h_ext[i*8 +: 8]    = hbuf[TAG_BYTES + LEN_WORD_BYTES + i];
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      h_key[i*8 +: 8] = hbuf[TAG_BYTES + LEN_WORD_BYTES + EXT_WORD_BYTES + i];
    end
  end

  assign dlen     = LEN_W'(h_framed - 32'(FRAME_EXTRA));
  assign framed_c = CW'(cur.length) + CW'(FRAME_EXTRA);
  assign hdr_vec  = {cur.unique_key[KEY_BYTES*8-1:0], cur.ext, 32'(framed_c), magic};
  assign rd_n     = (state == S_RD_HDR) ? CNT_W'(HB) : CNT_W'(TAG_BYTES);
  assign cfg_len  = cfg_data[LEN_W-1:0];

  always_comb begin
    if (wptr == rptr) free_b = CW'(ring_len);
    else if (rptr > wptr) free_b = CW'(rptr) - CW'(wptr);
    else free_b = CW'(ring_len) + CW'(rptr) - CW'(wptr);
  end

  always_comb begin
    state_next     = state;
    ring_len_next  = ring_len;
    magic_next     = magic;
    wptr_next      = wptr;
    rptr_next      = rptr;
    swptr_next     = swptr;
    srptr_next     = srptr;
    wk_next        = wk;
    wleft_next     = wleft;
    rleft_next     = rleft;
    wopen_next     = wopen;
    ropen_next     = ropen;
    enq_next       = enq;
    deq_next       = deq;
    cnt_next       = cnt;
    cur_next       = cur;
    res_next       = res;
    res_valid_next = res_valid && !res_ready;
    item_pop       = 1'b0;
    hb_we          = 1'b0;
    hb_idx         = HI_W'(cnt - CNT_W'(1));
    ram_we         = 1'b0;
    ram_waddr      = wk;
    ram_wdata      = '0;
    ram_raddr      = wk;

    case (state)
      S_IDLE: begin
        ram_raddr = srptr;
        if (item_valid && !res_valid) begin
          item_pop   = 1'b1;
          cur_next   = item;
          res_next   = '0;
          res_next.status = ST_SEQ;
          state_next = S_EMIT;
          wk_next    = wptr;
          cnt_next   = '0;
          case (item.op)
            OP_BEGIN_WR: begin
              if (!wopen) begin
                if (adv(wptr, ring_len) == rptr ||
                    (CW'(item.length) + CW'(FRAME_EXTRA)) >= free_b) begin
                  res_next.status = ST_FULL;
                end else begin
                  state_next = S_WR_HDR;
                end
              end
            end
            OP_WR_BYTE: begin
              if (wopen) begin
                ram_we     = 1'b1;
                ram_waddr  = swptr;
                ram_wdata  = item.data_byte;
                swptr_next = adv(swptr, ring_len);
                wleft_next = wleft - LEN_W'(1);
                res_next.status = ST_OK;
                if (wleft == LEN_W'(1)) begin
                  wk_next    = adv(swptr, ring_len);
                  state_next = S_WR_TAIL;
                end
              end
            end
            OP_BEGIN_RD: begin
              if (!ropen) begin
                if (wptr == rptr) begin
                  res_next.status = ST_EMPTY;
                end else begin
                  wk_next    = rptr;
                  state_next = S_RD_HDR;
                end
              end
            end
            OP_RD_BYTE: begin
              if (ropen) state_next = S_RD_BYTE;
            end
            OP_CLEAR: begin
              wptr_next = '0; rptr_next = '0; swptr_next = '0; srptr_next = '0;
              wleft_next = '0; rleft_next = '0; wopen_next = 1'b0; ropen_next = 1'b0;
              res_next.status = ST_OK;
            end
            default: ;
          endcase
        end
      end

      S_WR_HDR: begin
        ram_we    = 1'b1;
        ram_wdata = hdr_vec[cnt*8 +: 8];
        wk_next   = adv(wk, ring_len);
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(HB - 1)) begin
          swptr_next = adv(wk, ring_len);
          wleft_next = cur.length;
          wopen_next = 1'b1;
          res_next.status = ST_OK;
          cnt_next   = '0;
          state_next = (cur.length == '0) ? S_WR_TAIL : S_EMIT;
        end
      end

      S_WR_TAIL: begin
        ram_we    = 1'b1;
        ram_wdata = magic[cnt[1:0]*8 +: 8];
        wk_next   = adv(wk, ring_len);
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_W'(TAG_BYTES - 1)) begin
          wptr_next  = adv(wk, ring_len);
          swptr_next = adv(wk, ring_len);
          wopen_next = 1'b0;
          wleft_next = '0;
          enq_next   = enq + 32'd1;
          res_next.last = 1'b1;
          state_next = S_EMIT;
        end
      end

      // issue one address per cycle, capture the byte issued the cycle before
      S_RD_HDR, S_RD_TAIL: begin
        if (cnt < rd_n) begin
          wk_next  = adv(wk, ring_len);
          cnt_next = cnt + CNT_W'(1);
        end
        if (cnt != '0) hb_we = 1'b1;
        if (cnt == rd_n) state_next = (state == S_RD_HDR) ? S_RD_CHK : S_TAIL_CHK;
      end

      S_RD_CHK: begin
        state_next = S_EMIT;
        if (h_tag != magic || h_framed < 32'(FRAME_EXTRA) || h_framed >= 32'(ring_len)) begin
          wptr_next = '0; rptr_next = '0; swptr_next = '0; srptr_next = '0;
          wleft_next = '0; rleft_next = '0; wopen_next = 1'b0; ropen_next = 1'b0;
          res_next.status = ST_TAG;
        end else begin
          res_next.msg_length = dlen;
          res_next.msg_ext    = h_ext;
          res_next.msg_key    = h_key;
          if (dlen > cur.max_length) begin
            res_next.status = ST_SMALL;
          end else begin
            srptr_next = wk;
            rleft_next = dlen;
            ropen_next = 1'b1;
            res_next.status = ST_OK;
            cnt_next = '0;
            if (dlen == '0) state_next = S_RD_TAIL;
          end
        end
      end

      S_RD_BYTE: begin
        res_next.read_byte = ram_rdata;
        res_next.status    = ST_OK;
        srptr_next = adv(srptr, ring_len);
        rleft_next = rleft - LEN_W'(1);
        state_next = S_EMIT;
        if (rleft == LEN_W'(1)) begin
          wk_next    = adv(srptr, ring_len);
          cnt_next   = '0;
          state_next = S_RD_TAIL;
        end
      end

      S_TAIL_CHK: begin
        res_next.last = 1'b1;
        state_next    = S_EMIT;
        if (h_tag != magic) begin
          wptr_next = '0; rptr_next = '0; swptr_next = '0; srptr_next = '0;
          wleft_next = '0; rleft_next = '0; wopen_next = 1'b0; ropen_next = 1'b0;
          res_next.status = ST_TAG;
        end else begin
          rptr_next  = wk;
          srptr_next = wk;
          ropen_next = 1'b0;
          rleft_next = '0;
          deq_next   = deq + 32'd1;
        end
      end

      S_EMIT: begin
        res_next.enqueued_count = enq;
        res_next.dequeued_count = deq;
        res_valid_next = 1'b1;
        state_next     = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    // register writes are to arrive only while the engine is idle; the engine itself does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        REG_RING_LENGTH: begin
          if (CW'(cfg_len) < CW'(MIN_RING)) ring_len_next = LW'(MIN_RING);
          else if (CW'(cfg_len) > CW'(RING_BYTES)) ring_len_next = LW'(RING_BYTES);
          else ring_len_next = LW'(cfg_len);
          wptr_next = '0; rptr_next = '0; swptr_next = '0; srptr_next = '0;
          wleft_next = '0; rleft_next = '0; wopen_next = 1'b0; ropen_next = 1'b0;
        end
        REG_MAGIC_TAG: magic_next = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hb_we) hbuf[hb_idx] <= ram_rdata;
    cur <= cur_next;
    res <= res_next;
    wk  <= wk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ring_len  <= LW'(RING_BYTES);
      magic     <= '0;
      wptr      <= '0;
      rptr      <= '0;
      swptr     <= '0;
      srptr     <= '0;
      wleft     <= '0;
      rleft     <= '0;
      wopen     <= 1'b0;
      ropen     <= 1'b0;
      enq       <= '0;
      deq       <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ring_len  <= ring_len_next;
      magic     <= magic_next;
      wptr      <= wptr_next;
      rptr      <= rptr_next;
      swptr     <= swptr_next;
      srptr     <= srptr_next;
      wleft     <= wleft_next;
      rleft     <= rleft_next;
      wopen     <= wopen_next;
      ropen     <= ropen_next;
      enq       <= enq_next;
      deq       <= deq_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

>>> sv/framed_message_ring_buffer.sv
`timescale 1ns / 1ps
// Framed message ring buffer.
// Words enter on the s_ channel: s_tuser carries the operation (begin write,
// write byte, begin read, read byte, clear), s_tdata the arguments. Every
// word yields exactly one result word on the m_ channel: m_tuser carries the
// status, m_tlast marks the word that finished a message write or read.
// Messages live in a byte-wide single-port-per-direction ring memory, framed
// as head tag, length word, ext word, key, payload, tail tag.
// Work done per word, from the engine taking it to the result showing:
//   clear, refused or out-of-order words: result straight from idle
//   write/read byte: one payload byte, plus the tail tag when it ends a message
//   begin write: HEAD bytes written (tail tag too for an empty payload)
//   begin read: HEAD bytes read and checked (tail tag too for an empty payload)
// The ring memory port moves these bytes, one byte per cycle.
// A two-word input queue keeps taking words while a result waits; the
// engine starts the next word only once the result register is free, so a
// stalled receiver backs up into the queue and then into s_tready.
// Reset (synchronous, rst high) empties the ring, zeroes the counters, sets
// ring_length to RING_BYTES and magic_tag to zero. Ring contents are not
// cleared. Registers are written through cfg_we/cfg_index/cfg_data.
module framed_message_ring_buffer
  import fmrb_pkg::*;
#(
  parameter int RING_BYTES = RING_BYTES_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // length[12:0], ext[44:13], unique_key[108:45], data_byte[116:109],
  // max_length[129:117], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation[2:0]
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // msg_length[12:0], msg_ext[44:13], msg_key[108:45], read_byte[116:109],
  // enqueued_count[148:117], dequeued_count[180:149], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[2:0]
  output logic [2:0]            m_tuser,
  output logic                  m_tlast
);

  item_t   item;
  logic    item_valid, item_pop;
  result_t res;

  // accept and classify words, hold up to two ahead of the engine
  fmrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // carry out each word against the ring and hold its result
  fmrb_engine #(
    .RING_BYTES (RING_BYTES),
    .KEY_BYTES  (KEY_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (reg_idx_t'(cfg_index)),
    .cfg_data   (cfg_data),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res        (res),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready)
  );

  assign m_tuser = res.status;
  assign m_tlast = res.last;
  assign m_tdata = {3'b000, res.dequeued_count, res.enqueued_count, res.read_byte,
                    res.msg_key, res.msg_ext, res.msg_length};

endmodule
